@@ hdl/eihp_pkg.sv @@
// ----------------------------------------------------------------------------
// eihp_pkg
// Types, field codes and limits shared by the header parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package eihp_pkg;

   localparam int unsigned MaxFrameBytes = 16384;
   localparam int unsigned GroupSlots    = 3;
   localparam int unsigned QueueDepth    = 4;

   localparam logic [4:0] CODE_ETH_DST    = 5'd0;
   localparam logic [4:0] CODE_ETH_SRC    = 5'd1;
   localparam logic [4:0] CODE_ETH_TYPE   = 5'd2;
   localparam logic [4:0] CODE_ARP_OPER   = 5'd3;
   localparam logic [4:0] CODE_ARP_SHA    = 5'd4;
   localparam logic [4:0] CODE_ARP_SPA    = 5'd5;
   localparam logic [4:0] CODE_ARP_THA    = 5'd6;
   localparam logic [4:0] CODE_ARP_TPA    = 5'd7;
   localparam logic [4:0] CODE_IP_VER     = 5'd8;
   localparam logic [4:0] CODE_IP_IHL     = 5'd9;
   localparam logic [4:0] CODE_IP_DSCP    = 5'd10;
   localparam logic [4:0] CODE_IP_ECN     = 5'd11;
   localparam logic [4:0] CODE_IP_TTL     = 5'd12;
   localparam logic [4:0] CODE_IP_PROTO   = 5'd13;
   localparam logic [4:0] CODE_IP_CSUM    = 5'd14;
   localparam logic [4:0] CODE_IP_SRC     = 5'd15;
   localparam logic [4:0] CODE_IP_DST     = 5'd16;
   localparam logic [4:0] CODE_IP_OK      = 5'd17;
   localparam logic [4:0] CODE_ICMP_TYPE  = 5'd18;
   localparam logic [4:0] CODE_SRC_PORT   = 5'd19;
   localparam logic [4:0] CODE_DST_PORT   = 5'd20;
   localparam logic [4:0] CODE_TCP_SEQ    = 5'd21;
   localparam logic [4:0] CODE_TCP_ACK    = 5'd22;
   localparam logic [4:0] CODE_TCP_OFF    = 5'd23;
   localparam logic [4:0] CODE_TCP_FLAGS  = 5'd24;
   localparam logic [4:0] CODE_TCP_WIN    = 5'd25;
   localparam logic [4:0] CODE_TCP_CSUM   = 5'd26;
   localparam logic [4:0] CODE_TCP_OK     = 5'd27;
   localparam logic [4:0] CODE_FRAME_END  = 5'd28;

   localparam logic [15:0] ETYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   typedef enum logic [7:0] {
      PH_ETH  = 8'b00000001,
      PH_ARP  = 8'b00000010,
      PH_IP   = 8'b00000100,
      PH_ICMP = 8'b00001000,
      PH_UDP  = 8'b00010000,
      PH_TCPH = 8'b00100000,
      PH_TCPD = 8'b01000000,
      PH_IDLE = 8'b10000000
   } phase_type;

   typedef struct packed {
      logic [4:0]  code;
      logic [47:0] value;
      logic        trunc;
   } rec_type;

   typedef struct packed {
      rec_type [GroupSlots-1:0] rec;
      logic [1:0]               cnt;
   } group_type;

   function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
      logic [16:0] t;
      logic [16:0] r;
      t = {1'b0, s} + {1'b0, w};
      r = {1'b0, t[15:0]} + {16'd0, t[16]};
      return r[15:0];
   endfunction

endpackage

@@ hdl/eihp_parser.sv @@
// ----------------------------------------------------------------------------
// eihp_parser
// Per-byte header state and record builder; one byte per cycle on byte_en.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module eihp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_en,
   input  logic [7:0]          data_byte,
   input  logic                frame_last,
   output eihp_pkg::group_type group_out
);
   import eihp_pkg::*;

   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [47:0] acc_ff, acc_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] ipsum_ff, ipsum_in;
   logic [15:0] segsum_ff, segsum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] left_ff, left_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_ETH;
         acc_ff    <= '0;
         ihl_ff    <= '0;
         tlen_ff   <= '0;
         proto_ff  <= '0;
         ipsum_ff  <= '0;
         segsum_ff <= '0;
         hold_ff   <= '0;
         left_ff   <= '0;
      end else if (byte_en) begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         ihl_ff    <= ihl_in;
         tlen_ff   <= tlen_in;
         proto_ff  <= proto_in;
         ipsum_ff  <= ipsum_in;
         segsum_ff <= segsum_in;
         hold_ff   <= hold_in;
         left_ff   <= left_in;
      end
   end

   function automatic rec_type mk(input logic [4:0] c, input logic [47:0] v,
                                  input logic t);
      rec_type r;
      r.code  = c;
      r.value = v;
      r.trunc = t;
      return r;
   endfunction

   always_comb begin
      logic [15:0] off;
      logic [15:0] soff;
      logic [15:0] word;
      logic        have;
      logic [3:0]  h;
      logic [5:0]  hlen;
      logic [15:0] slen;
      logic [15:0] s;
      logic        ok;
      logic [1:0]  n;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      ihl_in    = ihl_ff;
      tlen_in   = tlen_ff;
      proto_in  = proto_ff;
      ipsum_in  = ipsum_ff;
      segsum_in = segsum_ff;
      hold_in   = hold_ff;
      left_in   = left_ff;
      word      = {hold_ff, data_byte};
      have      = pos_ff[0];
      off       = pos_ff - 16'd14;
      h         = ihl_ff;
      hlen      = 6'd20;
      slen      = '0;
      soff      = '0;
      s         = '0;
      ok        = 1'b0;
      n         = '0;
      group_out = '0;
      if (pos_ff < 16'(MaxFrameBytes)) begin
         pos_in = pos_ff + 16'd1;
         unique case (phase_ff)
            PH_ETH: begin
               acc_in = {acc_ff[39:0], data_byte};
               if (!have) hold_in = data_byte;
               if (pos_ff == 16'd5) begin
                  group_out.rec[n] = mk(CODE_ETH_DST, acc_in, 1'b0); n = n + 2'd1;
               end else if (pos_ff == 16'd11) begin
                  group_out.rec[n] = mk(CODE_ETH_SRC, acc_in, 1'b0); n = n + 2'd1;
               end else if (pos_ff == 16'd13) begin
                  group_out.rec[n] = mk(CODE_ETH_TYPE, {32'd0, acc_in[15:0]}, 1'b0);
                  n = n + 2'd1;
                  if (acc_in[15:0] == ETYPE_ARP) phase_in = PH_ARP;
                  else if (acc_in[15:0] == ETYPE_IPV4) phase_in = PH_IP;
                  else phase_in = PH_IDLE;
               end
            end
            PH_ARP: begin
               acc_in = {acc_ff[39:0], data_byte};
               if (!have) hold_in = data_byte;
               if (off == 16'd7) begin
                  group_out.rec[n] = mk(CODE_ARP_OPER, {32'd0, acc_in[15:0]}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd13) begin
                  group_out.rec[n] = mk(CODE_ARP_SHA, acc_in, 1'b0); n = n + 2'd1;
               end else if (off == 16'd17) begin
                  group_out.rec[n] = mk(CODE_ARP_SPA, {16'd0, acc_in[31:0]}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd23) begin
                  group_out.rec[n] = mk(CODE_ARP_THA, acc_in, 1'b0); n = n + 2'd1;
               end else if (off == 16'd27) begin
                  group_out.rec[n] = mk(CODE_ARP_TPA, {16'd0, acc_in[31:0]}, 1'b0);
                  n = n + 2'd1;
                  phase_in = PH_IDLE;
               end
            end
            PH_IP: begin
               acc_in = {acc_ff[39:0], data_byte};
               if (!have) hold_in = data_byte;
               if (have) begin
                  ipsum_in = oc_add(ipsum_ff, word);
                  if (off >= 16'd12 && off <= 16'd19) segsum_in = oc_add(segsum_ff, word);
               end
               if (off == 16'd0) begin
                  ihl_in = data_byte[3:0];
                  group_out.rec[n] = mk(CODE_IP_VER, {44'd0, data_byte[7:4]}, 1'b0);
                  n = n + 2'd1;
                  group_out.rec[n] = mk(CODE_IP_IHL, {44'd0, data_byte[3:0]}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd1) begin
                  group_out.rec[n] = mk(CODE_IP_DSCP, {42'd0, data_byte[7:2]}, 1'b0);
                  n = n + 2'd1;
                  group_out.rec[n] = mk(CODE_IP_ECN, {46'd0, data_byte[1:0]}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd3) begin
                  tlen_in = acc_in[15:0];
               end else if (off == 16'd8) begin
                  group_out.rec[n] = mk(CODE_IP_TTL, {40'd0, data_byte}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd9) begin
                  proto_in = data_byte;
                  group_out.rec[n] = mk(CODE_IP_PROTO, {40'd0, data_byte}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd11) begin
                  group_out.rec[n] = mk(CODE_IP_CSUM, {32'd0, acc_in[15:0]}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd15) begin
                  group_out.rec[n] = mk(CODE_IP_SRC, {16'd0, acc_in[31:0]}, 1'b0);
                  n = n + 2'd1;
               end else if (off == 16'd19) begin
                  group_out.rec[n] = mk(CODE_IP_DST, {16'd0, acc_in[31:0]}, 1'b0);
                  n = n + 2'd1;
               end
               h    = (ihl_in < 4'd5) ? 4'd5 : ihl_in;
               hlen = {h, 2'b00};
               slen = (tlen_in > {10'd0, hlen}) ? tlen_in - {10'd0, hlen} : 16'd0;
               if (off == {10'd0, hlen - 6'd1}) begin
                  group_out.rec[n] = mk(CODE_IP_OK, {47'd0, ipsum_in == 16'hFFFF}, 1'b0);
                  n = n + 2'd1;
                  left_in   = slen;
                  segsum_in = oc_add(oc_add(segsum_in, 16'd6), slen);
                  if (proto_in == PROTO_ICMP) phase_in = PH_ICMP;
                  else if (proto_in == PROTO_UDP) phase_in = PH_UDP;
                  else if (proto_in == PROTO_TCP) phase_in = PH_TCPH;
                  else phase_in = PH_IDLE;
               end
            end
            PH_ICMP, PH_UDP, PH_TCPH, PH_TCPD: begin
               if (left_ff != 16'd0) begin
                  left_in = left_ff - 16'd1;
                  acc_in  = {acc_ff[39:0], data_byte};
                  if (!have) hold_in = data_byte;
                  if (have) segsum_in = oc_add(segsum_ff, word);
                  h    = (ihl_ff < 4'd5) ? 4'd5 : ihl_ff;
                  hlen = {h, 2'b00};
                  soff = off - {10'd0, hlen};
                  if (phase_ff == PH_ICMP) begin
                     if (soff == 16'd0) begin
                        group_out.rec[n] = mk(CODE_ICMP_TYPE, {40'd0, data_byte}, 1'b0);
                        n = n + 2'd1;
                        phase_in = PH_IDLE;
                     end
                  end else if (phase_ff == PH_UDP) begin
                     if (soff == 16'd1) begin
                        group_out.rec[n] = mk(CODE_SRC_PORT, {32'd0, acc_in[15:0]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd3) begin
                        group_out.rec[n] = mk(CODE_DST_PORT, {32'd0, acc_in[15:0]}, 1'b0);
                        n = n + 2'd1;
                        phase_in = PH_IDLE;
                     end
                  end else if (phase_ff == PH_TCPH) begin
                     if (soff == 16'd1) begin
                        group_out.rec[n] = mk(CODE_SRC_PORT, {32'd0, acc_in[15:0]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd3) begin
                        group_out.rec[n] = mk(CODE_DST_PORT, {32'd0, acc_in[15:0]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd7) begin
                        group_out.rec[n] = mk(CODE_TCP_SEQ, {16'd0, acc_in[31:0]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd11) begin
                        group_out.rec[n] = mk(CODE_TCP_ACK, {16'd0, acc_in[31:0]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd12) begin
                        group_out.rec[n] = mk(CODE_TCP_OFF, {44'd0, data_byte[7:4]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd13) begin
                        group_out.rec[n] = mk(CODE_TCP_FLAGS, {40'd0, data_byte}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd15) begin
                        group_out.rec[n] = mk(CODE_TCP_WIN, {32'd0, acc_in[15:0]}, 1'b0);
                        n = n + 2'd1;
                     end else if (soff == 16'd17) begin
                        group_out.rec[n] = mk(CODE_TCP_CSUM, {32'd0, acc_in[15:0]}, 1'b0);
                        n = n + 2'd1;
                        phase_in = PH_TCPD;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (frame_last) begin
         h    = (ihl_in < 4'd5) ? 4'd5 : ihl_in;
         hlen = {h, 2'b00};
         slen = (tlen_in > {10'd0, hlen}) ? tlen_in - {10'd0, hlen} : 16'd0;
         if (phase_in == PH_TCPD) begin
            s  = segsum_in;
            ok = (left_in == 16'd0);
            if (ok && slen[0]) s = oc_add(s, {hold_in, 8'd0});
            group_out.rec[n] = mk(CODE_TCP_OK, {47'd0, ok && (s == 16'hFFFF)}, 1'b0);
            n = n + 2'd1;
         end
         group_out.rec[n] = mk(CODE_FRAME_END, {32'd0, pos_in},
                               (phase_in != PH_TCPD) && (phase_in != PH_IDLE));
         n = n + 2'd1;
         pos_in    = '0;
         phase_in  = PH_ETH;
         acc_in    = '0;
         ihl_in    = '0;
         tlen_in   = '0;
         proto_in  = '0;
         ipsum_in  = '0;
         segsum_in = '0;
         hold_in   = '0;
         left_in   = '0;
      end
      group_out.cnt = n;
   end

endmodule

@@ hdl/eihp_queue.sv @@
// ----------------------------------------------------------------------------
// eihp_queue
// Queue of record groups with a serializer that sends one record per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module eihp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  eihp_pkg::group_type push_group,
   output logic                full,
   output logic                out_valid,
   input  logic                out_ready,
   output eihp_pkg::rec_type   out_rec,
   output logic                out_last
);
   import eihp_pkg::*;

   localparam int unsigned PtrW = $clog2(QueueDepth);

   group_type           mem_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]       cnt_ff, cnt_in;
   logic [1:0]          idx_ff, idx_in;
   group_type           head;
   logic                pop;

   assign head      = mem_ff[rd_ff];
   assign full      = (cnt_ff == (PtrW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_rec   = head.rec[idx_ff];
   assign out_last  = (idx_ff == head.cnt - 2'd1);
   assign pop       = out_valid && out_ready && out_last;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      idx_in = idx_ff;
      if (out_valid && out_ready) idx_in = out_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_group;
   end

endmodule

@@ hdl/eth_ipv4_header_parser_checksum_top.sv @@
// ----------------------------------------------------------------------------
// eth_ipv4_header_parser_checksum_top
// Ethernet, ARP, IPv4, ICMP, UDP and TCP header parser with checksum checks.
//
//   Channel  Ports  Beat
//   input    req_   one frame byte and its last flag
//   output   rsp_   one field record (code, value, truncation, run end)
//
// One byte is taken per cycle; its records are built in that cycle and queued
// as a group of up to three. The output sends one record per beat, so a byte
// with several records holds the queue head until all are sent. Input stalls
// only when the four-group queue is full. Reset is synchronous and empties it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module eth_ipv4_header_parser_checksum_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_code,
   output logic [47:0] rsp_field_value,
   output logic        rsp_frame_truncated,
   output logic        rsp_run_last
);
   import eihp_pkg::*;

   logic      beat;
   logic      full;
   group_type grp;
   rec_type   rec;

   assign req_ready = !full;
   assign beat      = req_valid && req_ready;

   eihp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (beat),
      .data_byte  (req_data_byte),
      .frame_last (req_frame_last),
      .group_out  (grp)
   );

   eihp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (beat && (grp.cnt != 2'd0)),
      .push_group (grp),
      .full       (full),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_rec    (rec),
      .out_last   (rsp_run_last)
   );

   assign rsp_field_code      = rec.code;
   assign rsp_field_value     = rec.value;
   assign rsp_frame_truncated = rec.trunc;

endmodule
